// File: rtl/core/itrt_pkg.sv
package itrt_pkg;

    // digit buffer geometry: 2^63 in base two needs 64 digits
    localparam int MAX_DIGITS = 64;
    localparam int ADDR_W     = 6;
    localparam int CNT_W      = 7;
    localparam int DIGIT_W    = 4;
    localparam int RADIX_W    = 5;

    // bits of the magnitude consumed per division cycle
    localparam int BITS_PER_STEP = 8;
    localparam int STEP_W        = 3;

    localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;
    localparam logic [RADIX_W-1:0] BASE_MIN    = 5'd2;
    localparam logic [RADIX_W-1:0] BASE_MAX    = 5'd16;
    localparam logic [RADIX_W-1:0] BASE_DEC    = 5'd10;

    localparam logic [7:0] CHAR_MINUS  = 8'h2d;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_A_OFFS = 8'h57;  // 'a' minus ten

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_SIGN,
        ST_RD,
        ST_LD
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;       // capture a new value
        logic div_step;   // run one division cycle
        logic sign_load;  // put '-' into the output register
        logic rd;         // read the next digit from the buffer
        logic char_load;  // put the read digit into the output register
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic step_last;    // final cycle of the current digit
        logic quot_zero;    // quotient of this digit is zero
        logic sign_needed;  // negative value in base ten
        logic out_free;     // output register can take a character
        logic cnt_one;      // one digit left in the buffer
    } sts_t;

    // digit value to lower-case ASCII
    function automatic logic [7:0] digit_char(input logic [DIGIT_W-1:0] d);
        logic [7:0] d8;
        d8 = {4'd0, d};
        if (d < 4'd10) begin
            return CHAR_ZERO + d8;
        end
        return CHAR_A_OFFS + d8;
    endfunction

endpackage

// File: rtl/core/integer_to_radix_text_top.sv
// Integer to radix text: converts a signed 64-bit value to ASCII text in
// base 2 to 16, one character per output request, most significant first.
// Slave stream s_*: one value per request in s_tdata. Master stream m_*: one
// character per request in m_tdata, m_tlast high on the final character.
// Config channel cfg_*: 5-bit radix, to be written only while the block is
// idle; the block does not enforce this. Values below 2 act as 2, above 16
// as 16. A '-' leads only in base ten. The divider takes eight magnitude
// bits per cycle of a 64-bit long division for each digit; the characters
// then leave the registered-read digit buffer most significant first, a
// sign ahead of them when one is needed. A new value is taken once the last
// character is in the output register, while that character waits.
// Reset (aresetn low, synchronous) returns the radix to ten, empties the
// output register and aborts any conversion in progress; s_tready and
// cfg_ready stay low while it is held.
// A stalled m_tready holds the current character; the block waits.
module integer_to_radix_text_top import itrt_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    // value stream
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [63:0]  s_tdata,   // [63:0] value
    // character stream
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [7:0]   m_tdata,   // [7:0] char_code
    output logic         m_tlast,   // is_last
    // radix register
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [4:0]   cfg_data   // [4:0] radix
);

    cmd_t cmd;
    sts_t sts;

    assign cfg_ready = aresetn;

    itrt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    itrt_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .value     (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .char_code (m_tdata),
        .is_last   (m_tlast)
    );

endmodule

// File: rtl/core/itrt_ram.sv
module itrt_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/itrt_ctrl.sv
module itrt_ctrl import itrt_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg, state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = aresetn;
                if (s_tvalid && aresetn) begin
                    cmd.load   = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (sts.step_last && sts.quot_zero) begin
                    state_next = sts.sign_needed ? ST_SIGN : ST_RD;
                end
            end
            ST_SIGN: begin
                if (sts.out_free) begin
                    cmd.sign_load = 1'b1;
                    state_next    = ST_RD;
                end
            end
            ST_RD: begin
                cmd.rd     = 1'b1;
                state_next = ST_LD;
            end
            ST_LD: begin
                if (sts.out_free) begin
                    cmd.char_load = 1'b1;
                    state_next    = sts.cnt_one ? ST_IDLE : ST_RD;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/core/itrt_datapath.sv
module itrt_datapath import itrt_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [63:0]        value,
    input  logic               cfg_valid,
    input  logic [RADIX_W-1:0] cfg_data,
    input  cmd_t               cmd,
    output sts_t               sts,
    input  logic               m_tready,
    output logic               m_tvalid,
    output logic [7:0]         char_code,
    output logic               is_last
);

    logic [RADIX_W-1:0] radix_reg;
    logic [RADIX_W-1:0] base;
    logic [63:0]        mag_reg, mag_next;
    logic               neg_reg;
    logic [DIGIT_W-1:0] rem_reg, rem_next;
    logic [STEP_W-1:0]  step_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_dec;
    logic               out_valid_reg;
    logic [7:0]         out_char_reg;
    logic               out_last_reg;
    logic               out_free;
    logic               step_last;
    logic               ram_we;
    logic [DIGIT_W-1:0] ram_rdata;

    // radix register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radix_reg <= RADIX_RESET;
        end else if (cfg_valid) begin
            radix_reg <= cfg_data;
        end
    end

    // clamp the radix to the supported range
    always_comb begin
        if (radix_reg < BASE_MIN) begin
            base = BASE_MIN;
        end else if (radix_reg > BASE_MAX) begin
            base = BASE_MAX;
        end else begin
            base = radix_reg;
        end
    end

    // long division by the base, eight magnitude bits per cycle
    always_comb begin
        logic [DIGIT_W:0]         t;
        logic [DIGIT_W-1:0]       r;
        logic [BITS_PER_STEP-1:0] q;
        r = rem_reg;
        q = '0;
        for (int i = BITS_PER_STEP - 1; i >= 0; i--) begin
            t = {r, mag_reg[64 - BITS_PER_STEP + i]};
            if (t >= base) begin
                t    = t - base;
                q[i] = 1'b1;
            end
            r = t[DIGIT_W-1:0];
        end
        rem_next = r;
        mag_next = {mag_reg[63-BITS_PER_STEP:0], q};
    end

    assign step_last = (step_reg == {STEP_W{1'b1}});
    assign ram_we    = cmd.div_step && step_last;
    assign cnt_dec   = cnt_reg - 1'b1;

    // magnitude, remainder and digit counters
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            mag_reg  <= value[63] ? (64'd0 - value) : value;
            neg_reg  <= value[63];
            rem_reg  <= '0;
            step_reg <= '0;
            cnt_reg  <= '0;
        end else if (cmd.div_step) begin
            mag_reg  <= mag_next;
            step_reg <= step_reg + 1'b1;
            if (step_last) begin
                rem_reg <= '0;
                cnt_reg <= cnt_reg + 1'b1;
            end else begin
                rem_reg <= rem_next;
            end
        end else if (cmd.char_load) begin
            cnt_reg <= cnt_dec;
        end
    end

    // digits are stored least significant first and read back in reverse
    itrt_ram #(
        .WIDTH (DIGIT_W),
        .DEPTH (MAX_DIGITS)
    ) u_digits (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (cnt_reg[ADDR_W-1:0]),
        .wdata (rem_next),
        .re    (cmd.rd),
        .raddr (cnt_dec[ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    // output register
    assign out_free = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.sign_load || cmd.char_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.sign_load) begin
            out_char_reg <= CHAR_MINUS;
            out_last_reg <= 1'b0;
        end else if (cmd.char_load) begin
            out_char_reg <= digit_char(ram_rdata);
            out_last_reg <= (cnt_reg == {{(CNT_W-1){1'b0}}, 1'b1});
        end
    end

    assign m_tvalid  = out_valid_reg;
    assign char_code = out_char_reg;
    assign is_last   = out_last_reg;

    // status to the controller
    assign sts.step_last   = step_last;
    assign sts.quot_zero   = (mag_next == 64'd0);
    assign sts.sign_needed = neg_reg && (base == BASE_DEC);
    assign sts.out_free    = out_free;
    assign sts.cnt_one     = (cnt_reg == {{(CNT_W-1){1'b0}}, 1'b1});

endmodule

// File: rtl/core/itrt_checker.sv
module itrt_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata,
    input logic        m_tlast
);

    // stalled character stays offered
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("character dropped under stall");

    // stalled character does not change
    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
        else $error("character changed under stall");

    // a value occupies the divider right after its request
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second value taken during conversion");

    // only '-', '0'-'9' or 'a'-'f' appear
    a_charset: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata == 8'h2d)
                  || (m_tdata >= 8'h30 && m_tdata <= 8'h39)
                  || (m_tdata >= 8'h61 && m_tdata <= 8'h66))
        else $error("character outside digit set");

    // reset empties the output
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

endmodule

bind integer_to_radix_text_top itrt_checker u_chk (.*);

// File: dv/tb_integer_to_radix_text_top.sv
`timescale 1ns / 1ps

module tb_integer_to_radix_text_top;
    import itrt_pkg::*;

    localparam int IDLE_LIMIT   = 4000;  // cycles with no request on any channel
    localparam int TAIL_CYCLES  = 100;
    localparam int PHASE_ITEMS  = 10;
    localparam int MAX_REPORTS  = 100;

    typedef struct packed {
        logic [7:0] char_code;
        logic       is_last;
    } text_char_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [4:0]  cfg_data  = '0;

    text_char_t       chars_due[$];
    logic [4:0]       radix_now   = RADIX_RESET;
    int               mismatch_count = 0;
    int               idle_cycles    = 0;
    int               stall_left     = 0;
    bit               send_idle_on   = 1'b1;
    bit               recv_idle_on   = 1'b1;
    bit               valid_held     = 1'b0;

    integer_to_radix_text_top u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // 8 ns clock
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // gap length: mostly none or short, now and then long
    function automatic int pick_gap(input bit enabled);
        int r;
        r = $urandom_range(0, 99);
        if (!enabled || r < 55) begin
            return 0;
        end
        if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(4, 40);
    endfunction

    // random value: full width, short magnitudes of either sign, corners
    function automatic logic [63:0] random_value();
        logic [63:0] v;
        int sel;
        v   = {$urandom, $urandom};
        sel = $urandom_range(0, 9);
        case (sel)
            0, 1, 2: begin
            end
            3, 4, 5: begin
                v = v >> $urandom_range(0, 63);
            end
            6, 7: begin
                v = -(v >> $urandom_range(0, 63));
            end
            8: begin
                v = 64'($signed($urandom_range(0, 80)) - 40);
            end
            default: begin
                case ($urandom_range(0, 5))
                    0: v = 64'h0;
                    1: v = '1;
                    2: v = 64'h1;
                    3: v = 64'h8000_0000_0000_0000;
                    4: v = 64'h7fff_ffff_ffff_ffff;
                    default: v = 64'h8000_0000_0000_0001;
                endcase
            end
        endcase
        return v;
    endfunction

    // expected text of one value at the current radix
    task automatic predict_radix_text(input logic [63:0] value);
        logic [63:0] mag;
        logic [63:0] base;
        logic [3:0]  d;
        logic [7:0]  text[$];
        text_char_t  tc;
        if (radix_now < 5'd2) begin
            base = 64'd2;
        end else if (radix_now > 5'd16) begin
            base = 64'd16;
        end else begin
            base = 64'(radix_now);
        end
        mag = value[63] ? (64'h0 - value) : value;
        // digits come out least significant first
        do begin
            d = 4'(mag % base);
            text.push_front((d < 4'd10) ? (8'h30 + 8'(d)) : (8'h61 + 8'(d) - 8'd10));
            mag = mag / base;
        end while (mag != 64'h0);
        if (value[63] && base == 64'd10) begin
            text.push_front(8'h2d);
        end
        foreach (text[i]) begin
            tc.char_code = text[i];
            tc.is_last   = (i == text.size() - 1);
            chars_due.push_back(tc);
        end
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (mismatch_count < MAX_REPORTS) begin
            $display("[%0t] mismatch %s: got %0h, want %0h", $realtime, what, got, want);
        end
        mismatch_count++;
    endtask

    // one value request, expectation queued at acceptance
    task automatic send_value(input logic [63:0] value);
        int gap;
        gap = pick_gap(send_idle_on);
        if (gap != 0) begin
            if (valid_held) begin
                s_tvalid <= 1'b0;
                valid_held = 1'b0;
            end
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        valid_held = 1'b1;
        do @(posedge aclk); while (!s_tready);
        predict_radix_text(value);
    endtask

    // hold off the sender until every pending character has arrived
    task automatic wait_for_text();
        if (valid_held) begin
            s_tvalid <= 1'b0;
            valid_held = 1'b0;
        end
        while (chars_due.size() != 0) @(posedge aclk);
    endtask

    task automatic write_radix(input logic [4:0] r);
        wait_for_text();
        cfg_valid <= 1'b1;
        cfg_data  <= r;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        radix_now = r;
    endtask

    // reset value of the register is ten
    task automatic test_default_radix();
        send_value(64'h0);
        send_value('1);
        send_value(64'd9);
        send_value(64'h7fff_ffff_ffff_ffff);
        send_value(64'h8000_0000_0000_0000);
    endtask

    // bases at and past both ends, all letter digits, sign only in base ten
    task automatic test_radix_limits();
        write_radix(5'd2);
        send_value(64'h8000_0000_0000_0000);
        send_value(64'h0);
        write_radix(5'd16);
        send_value('1);
        send_value(64'hfedc_ba98_7654_3210);
        write_radix(5'd0);
        send_value(64'd5);
        write_radix(5'd1);
        send_value(-64'sd2);
        write_radix(5'd17);
        send_value(64'd255);
        write_radix(5'd31);
        send_value(64'h8000_0000_0000_0000);
        write_radix(5'd10);
        send_value(-64'sd9);
        send_value(64'd10);
        write_radix(5'd3);
        send_value(64'h7fff_ffff_ffff_ffff);
        write_radix(5'd7);
        send_value(64'h7fff_ffff_ffff_ffff);
    endtask

    // every register value once, in random order, random values per phase
    task automatic test_random_values();
        int order[32];
        int j;
        int t;
        foreach (order[i]) begin
            order[i] = i;
        end
        for (int i = 31; i > 0; i--) begin
            j        = $urandom_range(0, i);
            t        = order[i];
            order[i] = order[j];
            order[j] = t;
        end
        foreach (order[i]) begin
            write_radix(5'(order[i]));
            send_idle_on = ($urandom_range(0, 3) != 0);
            recv_idle_on = ($urandom_range(0, 3) != 0);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(0, 19) == 0) begin
                    wait_for_text();
                end
                send_value(random_value());
            end
        end
        send_idle_on = 1'b1;
        recv_idle_on = 1'b1;
    endtask

    // sink side stalls
    always @(posedge aclk) begin
        if (stall_left != 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (recv_idle_on && $urandom_range(0, 3) == 0) begin
            m_tready   <= 1'b0;
            stall_left <= pick_gap(1'b1);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // compare each character request with the oldest expectation
    always @(posedge aclk) begin
        text_char_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (chars_due.size() == 0) begin
                report_mismatch("unexpected char_code", 64'(m_tdata), 64'h0);
            end else begin
                want = chars_due.pop_front();
                if (m_tdata !== want.char_code) begin
                    report_mismatch("char_code", 64'(m_tdata), 64'(want.char_code));
                end
                if (m_tlast !== want.is_last) begin
                    report_mismatch("is_last", 64'(m_tlast), 64'(want.is_last));
                end
            end
        end
    end

    // stop a hung run
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= IDLE_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_default_radix();
        test_radix_limits();
        test_random_values();
        wait_for_text();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && chars_due.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
